// ===== sv/mpbm_pkg.sv =====
// mpbm_pkg: types, constants and codes for the multi-pattern byte matcher.
// Used by mpbm_store, mpbm_ctrl and multi_pattern_byte_matcher; no dependencies.
`timescale 1ns / 1ps
package mpbm_pkg;

   // Trie and dictionary sizes
   localparam int TRIE_NODES      = 256;
   localparam int MAX_PATTERN_LEN = 16;
   localparam int MAX_PATTERNS    = 256;
   localparam int RESULT_CAP      = 16;

   localparam int NODE_W      = $clog2(TRIE_NODES);
   localparam int CHILD_W     = NODE_W + 8;
   localparam int CHILD_DEPTH = TRIE_NODES * 256;
   localparam int LEN_W       = $clog2(MAX_PATTERN_LEN + 1);
   localparam int CNT_W       = $clog2(RESULT_CAP + 1);

   // Command codes
   localparam logic [1:0] CMD_ADD     = 2'd0;
   localparam logic [1:0] CMD_SCAN    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_LONG = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] symbol;
      logic       pattern_end;
      logic [7:0] pattern_id;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  match_id;
      logic [31:0] start_position;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // Storage requests from the sequencer
   typedef struct packed {
      logic               child_we;
      logic [CHILD_W-1:0] child_waddr;
      logic [NODE_W-1:0]  child_wdata;
      logic [CHILD_W-1:0] child_raddr;
      logic [NODE_W-1:0]  node_raddr;
      logic               link_we;
      logic [NODE_W-1:0]  link_waddr;
      logic [NODE_W-1:0]  link_wdata;
      logic               term_we;
      logic [NODE_W-1:0]  term_waddr;
      logic               term_wdata;
      logic               pat_we;
      logic [NODE_W-1:0]  pat_waddr;
      logic [7:0]         pat_wdata;
      logic               depth_we;
      logic [NODE_W-1:0]  depth_waddr;
      logic [LEN_W-1:0]   depth_wdata;
   } store_cmd_type;

   // Registered read data back from storage
   typedef struct packed {
      logic [NODE_W-1:0] child_q;
      logic [NODE_W-1:0] link_q;
      logic              term_q;
      logic [7:0]        pat_q;
      logic [LEN_W-1:0]  depth_q;
   } store_rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD,
      S_ADD_CHK,
      S_OUT,
      S_B_START,
      S_B_POP,
      S_B_POP2,
      S_B_POP3,
      S_B_SYM_RD,
      S_B_SYM_CHK,
      S_B_F_TEST,
      S_B_F_CHK,
      S_B_F_LINK,
      S_B_F_SET,
      S_B_NEXT,
      S_GO,
      S_G_TEST,
      S_G_CHK,
      S_G_LINK,
      S_W_TEST,
      S_W_CHK,
      S_W_END
   } ctrl_state_type;

endpackage

// ===== sv/multi_pattern_byte_matcher.sv =====
// multi_pattern_byte_matcher: top level of the multi-pattern byte matcher.
// Depends on mpbm_pkg, mpbm_store and mpbm_ctrl.
`timescale 1ns / 1ps
// Aho-Corasick matcher over bytes. After reset a clearing pass over the TRIE_NODES*256
// entries (65536 by default) zeroes the child table; no request is taken meanwhile.
// One request is worked at a time under a single sequencer around one child-table
// read port and one node-memory read port, each with registered read data. An add
// reads one child entry, then inserts or follows it. A scan follows failure links
// until a child is found, then walks the suffix chain and reports each match, with
// at most 16 matches, longest first, the last flagged by last. The first scan after
// a node is added first rebuilds all suffix links, breadth first over every node
// and all 256 symbols of each, before the goto step. Results leave through an
// output register, so the next request can be taken while a result waits.
module multi_pattern_byte_matcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mpbm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mpbm_pkg::rsp_type rsp_data
);
   import mpbm_pkg::*;

   store_cmd_type st_cmd;
   store_rsp_type st_rsp;

   mpbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .st_cmd    (st_cmd),
      .st_rsp    (st_rsp)
   );

   mpbm_store u_store (
      .clock (clock),
      .cmd   (st_cmd),
      .rsp   (st_rsp)
   );

endmodule

// ===== sv/mpbm_store.sv =====
// mpbm_store: trie storage - child table and per-node link, terminal, id and depth.
// Depends on mpbm_pkg. All reads are registered, one read address per memory group.
`timescale 1ns / 1ps
module mpbm_store (
   input  logic                   clock,
   input  mpbm_pkg::store_cmd_type cmd,
   output mpbm_pkg::store_rsp_type rsp
);
   import mpbm_pkg::*;

   logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
   logic [NODE_W-1:0] link_mem  [TRIE_NODES];
   logic              term_mem  [TRIE_NODES];
   logic [7:0]        pat_mem   [TRIE_NODES];
   logic [LEN_W-1:0]  depth_mem [TRIE_NODES];

   // Child table: one write, one read port
   always_ff @(posedge clock) begin
      if (cmd.child_we) begin
         child_mem[cmd.child_waddr] <= cmd.child_wdata;
      end
      rsp.child_q <= child_mem[cmd.child_raddr];
   end

   // Per-node memories, read together at one node address
   always_ff @(posedge clock) begin
      if (cmd.link_we) begin
         link_mem[cmd.link_waddr] <= cmd.link_wdata;
      end
      if (cmd.term_we) begin
         term_mem[cmd.term_waddr] <= cmd.term_wdata;
      end
      if (cmd.pat_we) begin
         pat_mem[cmd.pat_waddr] <= cmd.pat_wdata;
      end
      if (cmd.depth_we) begin
         depth_mem[cmd.depth_waddr] <= cmd.depth_wdata;
      end
      rsp.link_q  <= link_mem[cmd.node_raddr];
      rsp.term_q  <= term_mem[cmd.node_raddr];
      rsp.pat_q   <= pat_mem[cmd.node_raddr];
      rsp.depth_q <= depth_mem[cmd.node_raddr];
   end

endmodule

// ===== sv/mpbm_ctrl.sv =====
// mpbm_ctrl: sequencer for insert, suffix-link rebuild, scan and match walk.
// Depends on mpbm_pkg; drives mpbm_store through one request struct.
`timescale 1ns / 1ps
module mpbm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mpbm_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mpbm_pkg::rsp_type       rsp_data,
   output mpbm_pkg::store_cmd_type st_cmd,
   input  mpbm_pkg::store_rsp_type st_rsp
);
   import mpbm_pkg::*;

   // Control registers
   ctrl_state_type     state_ff, state_in, ret_ff, ret_in;
   logic [CHILD_W-1:0] sweep_ff, sweep_in;
   logic [NODE_W:0]    ncount_ff, ncount_in;
   logic [NODE_W-1:0]  cursor_ff, cursor_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [1:0]         drop_ff, drop_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [31:0]        pos_ff, pos_in;
   logic               links_ok_ff, links_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               pend_ff, pend_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [NODE_W-1:0]  head_ff, head_in, tail_ff, tail_in;

   // Payload registers
   req_type            item_ff, item_in;
   rsp_type            out_ff, out_in, rsp_ff, rsp_in;
   rsp_type            pres_ff, pres_in;
   logic [NODE_W-1:0]  node_ff, node_in, u_ff, u_in, fu_ff, fu_in;
   logic [NODE_W-1:0]  v_ff, v_in, f_ff, f_in;
   logic [7:0]         sym_ff, sym_in;
   logic               is_root_ff, is_root_in;

   // Breadth-first queue
   logic [NODE_W-1:0]  q_mem [TRIE_NODES];
   logic [NODE_W-1:0]  q_q_ff;
   logic               q_we;

   logic               mark;
   logic [31:0]        start_pos;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign mark      = item_ff.pattern_end && (32'(item_ff.pattern_id) < MAX_PATTERNS);
   assign start_pos = pos_ff - 32'(st_rsp.depth_q) + 32'd1;

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[tail_ff] <= v_ff;
      end
      q_q_ff <= q_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ret_ff       <= S_IDLE;
         sweep_ff     <= '0;
         ncount_ff    <= (NODE_W+1)'(1);
         cursor_ff    <= '0;
         len_ff       <= '0;
         drop_ff      <= STATUS_OK;
         cur_ff       <= '0;
         pos_ff       <= '0;
         links_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         n_ff         <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         sweep_ff     <= sweep_in;
         ncount_ff    <= ncount_in;
         cursor_ff    <= cursor_in;
         len_ff       <= len_in;
         drop_ff      <= drop_in;
         cur_ff       <= cur_in;
         pos_ff       <= pos_in;
         links_ok_ff  <= links_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         n_ff         <= n_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      out_ff     <= out_in;
      rsp_ff     <= rsp_in;
      pres_ff    <= pres_in;
      node_ff    <= node_in;
      u_ff       <= u_in;
      fu_ff      <= fu_in;
      v_ff       <= v_in;
      f_ff       <= f_in;
      sym_ff     <= sym_in;
      is_root_ff <= is_root_in;
   end

   // Next state and storage requests
   always_comb begin
      logic [NODE_W-1:0] tgt;
      logic              add_ok;

      tgt          = '0;
      add_ok       = 1'b0;
      state_in     = state_ff;
      ret_in       = ret_ff;
      sweep_in     = sweep_ff;
      ncount_in    = ncount_ff;
      cursor_in    = cursor_ff;
      len_in       = len_ff;
      drop_in      = drop_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      links_ok_in  = links_ok_ff;
      pend_in      = pend_ff;
      n_in         = n_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      item_in      = item_ff;
      out_in       = out_ff;
      rsp_in       = rsp_ff;
      pres_in      = pres_ff;
      node_in      = node_ff;
      u_in         = u_ff;
      fu_in        = fu_ff;
      v_in         = v_ff;
      f_in         = f_ff;
      sym_in       = sym_ff;
      is_root_in   = is_root_ff;
      q_we         = 1'b0;
      st_cmd       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         // Zero the child table and terminal flags after reset
         S_CLEAR: begin
            st_cmd.child_we    = 1'b1;
            st_cmd.child_waddr = sweep_ff;
            st_cmd.term_we     = 1'b1;
            st_cmd.term_waddr  = sweep_ff[NODE_W-1:0];
            sweep_in           = sweep_ff + CHILD_W'(1);
            if (sweep_ff == '1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               out_in  = '0;
               out_in.last = 1'b1;
               ret_in  = S_IDLE;
               unique case (req_data.command)
                  CMD_ADD:  state_in = S_ADD;
                  CMD_SCAN: state_in = links_ok_ff ? S_GO : S_B_START;
                  CMD_RESTART: begin
                     cur_in   = '0;
                     pos_in   = '0;
                     state_in = S_OUT;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end

         // Pattern insert
         S_ADD: begin
            if (drop_ff != STATUS_OK) begin
               out_in.status = drop_ff;
               state_in      = S_OUT;
            end else if (len_ff >= LEN_W'(MAX_PATTERN_LEN)) begin
               out_in.status = STATUS_LONG;
               drop_in       = STATUS_LONG;
               state_in      = S_OUT;
            end else begin
               st_cmd.child_raddr = {cursor_ff, item_ff.symbol};
               state_in           = S_ADD_CHK;
            end
            if (item_ff.pattern_end && (drop_ff != STATUS_OK
                  || len_ff >= LEN_W'(MAX_PATTERN_LEN))) begin
               cursor_in = '0;
               len_in    = '0;
               drop_in   = STATUS_OK;
            end
         end

         S_ADD_CHK: begin
            if (st_rsp.child_q == '0 && ncount_ff == (NODE_W+1)'(TRIE_NODES)) begin
               out_in.status = STATUS_FULL;
               drop_in       = STATUS_FULL;
            end else if (st_rsp.child_q == '0) begin
               tgt                = ncount_ff[NODE_W-1:0];
               add_ok             = 1'b1;
               ncount_in          = ncount_ff + (NODE_W+1)'(1);
               links_ok_in        = 1'b0;
               st_cmd.child_we    = 1'b1;
               st_cmd.child_waddr = {cursor_ff, item_ff.symbol};
               st_cmd.child_wdata = tgt;
               st_cmd.depth_we    = 1'b1;
               st_cmd.depth_waddr = tgt;
               st_cmd.depth_wdata = len_ff + LEN_W'(1);
               st_cmd.term_we     = 1'b1;
            end else begin
               tgt            = st_rsp.child_q;
               add_ok         = 1'b1;
               st_cmd.term_we = mark;
            end
            if (add_ok) begin
               cursor_in         = tgt;
               len_in            = len_ff + LEN_W'(1);
               st_cmd.term_waddr = tgt;
               st_cmd.term_wdata = mark;
               st_cmd.pat_we     = mark;
               st_cmd.pat_waddr  = tgt;
               st_cmd.pat_wdata  = item_ff.pattern_id;
            end
            if (item_ff.pattern_end) begin
               cursor_in = '0;
               len_in    = '0;
               drop_in   = STATUS_OK;
            end
            state_in = S_OUT;
         end

         // Hand one result to the output register
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = out_ff;
               state_in     = ret_ff;
            end
         end

         // Suffix-link rebuild, breadth first from the root
         S_B_START: begin
            u_in       = '0;
            is_root_in = 1'b1;
            sym_in     = '0;
            head_in    = '0;
            tail_in    = '0;
            state_in   = S_B_SYM_RD;
         end

         S_B_POP: begin
            if (head_ff == tail_ff) begin
               links_ok_in = 1'b1;
               state_in    = S_GO;
            end else begin
               state_in = S_B_POP2;
            end
         end

         S_B_POP2: begin
            u_in              = q_q_ff;
            head_in           = head_ff + NODE_W'(1);
            st_cmd.node_raddr = q_q_ff;
            state_in          = S_B_POP3;
         end

         S_B_POP3: begin
            fu_in      = st_rsp.link_q;
            sym_in     = '0;
            is_root_in = 1'b0;
            state_in   = S_B_SYM_RD;
         end

         S_B_SYM_RD: begin
            st_cmd.child_raddr = {u_ff, sym_ff};
            state_in           = S_B_SYM_CHK;
         end

         S_B_SYM_CHK: begin
            v_in = st_rsp.child_q;
            if (st_rsp.child_q == '0) begin
               state_in = S_B_NEXT;
            end else if (is_root_ff) begin
               st_cmd.link_we    = 1'b1;
               st_cmd.link_waddr = st_rsp.child_q;
               state_in          = S_B_F_SET;
            end else begin
               f_in     = fu_ff;
               state_in = S_B_F_TEST;
            end
         end

         S_B_F_TEST: begin
            st_cmd.child_raddr = {f_ff, sym_ff};
            state_in           = (f_ff == '0) ? S_B_F_SET : S_B_F_CHK;
         end

         S_B_F_CHK: begin
            if (st_rsp.child_q != '0) begin
               state_in = S_B_F_SET;
               st_cmd.link_we    = 1'b1;
               st_cmd.link_waddr = v_ff;
               st_cmd.link_wdata = st_rsp.child_q;
               q_we              = 1'b1;
               tail_in           = tail_ff + NODE_W'(1);
               state_in          = S_B_NEXT;
            end else begin
               st_cmd.node_raddr = f_ff;
               state_in          = S_B_F_LINK;
            end
         end

         S_B_F_LINK: begin
            f_in     = st_rsp.link_q;
            state_in = S_B_F_TEST;
         end

         // Root children link to the root; others take the looked-up child
         S_B_F_SET: begin
            if (!is_root_ff) begin
               st_cmd.link_we    = 1'b1;
               st_cmd.link_waddr = v_ff;
               st_cmd.link_wdata = st_rsp.child_q;
            end
            q_we     = 1'b1;
            tail_in  = tail_ff + NODE_W'(1);
            state_in = S_B_NEXT;
         end

         S_B_NEXT: begin
            sym_in   = sym_ff + 8'd1;
            state_in = (sym_ff == 8'hFF) ? S_B_POP : S_B_SYM_RD;
         end

         // Goto/failure transition for one text byte
         S_GO: begin
            node_in  = cur_ff;
            pend_in  = 1'b0;
            n_in     = '0;
            state_in = S_G_TEST;
         end

         S_G_TEST: begin
            st_cmd.child_raddr = {node_ff, item_ff.symbol};
            state_in           = S_G_CHK;
         end

         S_G_CHK: begin
            if (node_ff == '0 || st_rsp.child_q != '0) begin
               node_in  = st_rsp.child_q;
               cur_in   = st_rsp.child_q;
               state_in = S_W_TEST;
            end else begin
               st_cmd.node_raddr = node_ff;
               state_in          = S_G_LINK;
            end
         end

         S_G_LINK: begin
            node_in  = st_rsp.link_q;
            state_in = S_G_TEST;
         end

         // Suffix-chain walk; one match held back to know which is last
         S_W_TEST: begin
            if (node_ff == '0 || n_ff == CNT_W'(RESULT_CAP)) begin
               state_in = S_W_END;
            end else begin
               st_cmd.node_raddr = node_ff;
               state_in          = S_W_CHK;
            end
         end

         S_W_CHK: begin
            node_in  = st_rsp.link_q;
            state_in = S_W_TEST;
            if (st_rsp.term_q) begin
               pres_in.found          = 1'b1;
               pres_in.match_id       = st_rsp.pat_q;
               pres_in.start_position = start_pos;
               pres_in.status         = STATUS_OK;
               pres_in.last           = 1'b0;
               pend_in                = 1'b1;
               n_in                   = n_ff + CNT_W'(1);
               if (pend_ff) begin
                  out_in   = pres_ff;
                  ret_in   = S_W_TEST;
                  state_in = S_OUT;
               end
            end
         end

         S_W_END: begin
            pos_in = pos_ff + 32'd1;
            if (pend_ff) begin
               out_in      = pres_ff;
               out_in.last = 1'b1;
            end else begin
               out_in      = '0;
               out_in.last = 1'b1;
            end
            pend_in  = 1'b0;
            ret_in   = S_IDLE;
            state_in = S_OUT;
         end

         default: state_in = S_IDLE;
      endcase
   end

endmodule
